[rtl/cte_pkg.sv]
// ----------------------------------------------------------------------------
// cte_pkg
// Shared types, constants and small arithmetic helpers for the Toeplitz
// entry address generator.
// ----------------------------------------------------------------------------
package cte_pkg;

    localparam int DILATION     = 1;
    localparam int MAX_CHANNELS = 256;
    localparam int MAX_KERNEL   = 16;
    localparam int MAX_DIM      = 256;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // reciprocals scaled by 2**16, exact for the narrow operands used here
    localparam logic [15:0] RECIP_3  = 16'd21846;
    localparam logic [15:0] RECIP_5  = 16'd13108;
    localparam logic [15:0] RECIP_6  = 16'd10923;
    localparam logic [15:0] RECIP_7  = 16'd9363;
    localparam logic [15:0] RECIP_9  = 16'd7282;
    localparam logic [15:0] RECIP_25 = 16'd2622;
    localparam logic [15:0] RECIP_36 = 16'd1821;
    localparam logic [15:0] RECIP_49 = 16'd1338;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_HEIGHT  = 3'd0,
        REG_IMAGE_WIDTH   = 3'd1,
        REG_RESULT_HEIGHT = 3'd2,
        REG_RESULT_WIDTH  = 3'd3,
        REG_STEP_SIZE     = 3'd4,
        REG_PAD_AMOUNT    = 3'd5,
        REG_IN_GAP        = 3'd6,
        REG_OUT_GAP       = 3'd7
    } cte_reg_t;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_ZERO   = 2'd1,
        ST_PAD    = 2'd2,
        ST_RANGE  = 2'd3
    } cte_status_t;

    typedef struct packed {
        logic [8:0]  image_height;
        logic [8:0]  image_width;
        logic [8:0]  result_height;
        logic [8:0]  result_width;
        logic [4:0]  step_size;
        logic [3:0]  pad_amount;
        logic [3:0]  in_gap;
        logic [3:0]  out_gap;
        logic [6:0]  in_gap_sq;
        logic [6:0]  out_gap_sq;
        logic [11:0] full_in_h;
        logic [11:0] full_in_w;
        logic [11:0] full_out_h;
        logic [11:0] full_out_w;
    } cte_cfg_t;

    // 8-bit value divided by gap squared, gap in 1..8
    function automatic logic [7:0] div_by_gap_sq(logic [7:0] v, logic [3:0] g);
        logic [23:0] p;
        logic [7:0]  r;
        p = '0;
        case (g)
            4'd1: r = v;
            4'd2: r = v >> 2;
            4'd3:
            begin
                p = 24'(v) * 24'(RECIP_9);
                r = p[23:16];
            end
            4'd4: r = v >> 4;
            4'd5:
            begin
                p = 24'(v) * 24'(RECIP_25);
                r = p[23:16];
            end
            4'd6:
            begin
                p = 24'(v) * 24'(RECIP_36);
                r = p[23:16];
            end
            4'd7:
            begin
                p = 24'(v) * 24'(RECIP_49);
                r = p[23:16];
            end
            default: r = v >> 6;
        endcase
        return r;
    endfunction

    // 6-bit value divided by gap, gap in 1..8
    function automatic logic [2:0] div_by_gap(logic [5:0] v, logic [3:0] g);
        logic [21:0] p;
        logic [5:0]  r;
        p = '0;
        case (g)
            4'd1: r = v;
            4'd2: r = v >> 1;
            4'd3:
            begin
                p = 22'(v) * 22'(RECIP_3);
                r = p[21:16];
            end
            4'd4: r = v >> 2;
            4'd5:
            begin
                p = 22'(v) * 22'(RECIP_5);
                r = p[21:16];
            end
            4'd6:
            begin
                p = 22'(v) * 22'(RECIP_6);
                r = p[21:16];
            end
            4'd7:
            begin
                p = 22'(v) * 22'(RECIP_7);
                r = p[21:16];
            end
            default: r = v >> 3;
        endcase
        // block offset is below gap squared, so the quotient is below gap
        return r[2:0];
    endfunction

endpackage

[rtl/cte_in_if.sv]
// ----------------------------------------------------------------------------
// cte_in_if
// Kernel weight channel: one word per weight and output position.
// ----------------------------------------------------------------------------
interface cte_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         out_chan;
    logic [7:0]         in_chan;
    logic [3:0]         tap_row;
    logic [3:0]         tap_col;
    logic [7:0]         pos_row;
    logic [7:0]         pos_col;
    logic signed [31:0] weight_in;

    modport source (
        output valid, out_chan, in_chan, tap_row, tap_col, pos_row, pos_col, weight_in,
        input  ready
    );
    modport sink (
        input  valid, out_chan, in_chan, tap_row, tap_col, pos_row, pos_col, weight_in,
        output ready
    );
endinterface

[rtl/cte_out_if.sv]
// ----------------------------------------------------------------------------
// cte_out_if
// Matrix entry channel: status, row, column and weight of one entry.
// ----------------------------------------------------------------------------
interface cte_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [23:0]        matrix_row;
    logic [23:0]        matrix_col;
    logic signed [31:0] weight_out;

    modport source (
        output valid, status, matrix_row, matrix_col, weight_out,
        input  ready
    );
    modport sink (
        input  valid, status, matrix_row, matrix_col, weight_out,
        output ready
    );
endinterface

[rtl/cte_cfg_if.sv]
// ----------------------------------------------------------------------------
// cte_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cte_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cte_pkg::CFG_INDEX_W-1:0]  index;
    logic [cte_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/cte_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cte_cfg_regs
// Configuration registers with write-time clamping, plus registered
// derived sizes (gap squares and multiplexed plane dimensions).
// ----------------------------------------------------------------------------
module cte_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    cte_cfg_if.sink          cfg,
    output cte_pkg::cte_cfg_t regs
);

    logic [8:0] image_height_reg, image_width_reg;
    logic [8:0] result_height_reg, result_width_reg;
    logic [4:0] step_size_reg;
    logic [3:0] pad_amount_reg, in_gap_reg, out_gap_reg;

    logic [6:0]  in_gap_sq_reg, out_gap_sq_reg;
    logic [11:0] full_in_h_reg, full_in_w_reg, full_out_h_reg, full_out_w_reg;

    logic [8:0] dim_next;
    logic [4:0] step_next;
    logic [3:0] gap_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        dim_next = cfg.data[8:0];
        if (dim_next == 9'd0)
            dim_next = 9'd1;
        else if (dim_next > 9'(cte_pkg::MAX_DIM))
            dim_next = 9'(cte_pkg::MAX_DIM);

        step_next = cfg.data[4:0];
        if (step_next == 5'd0)
            step_next = 5'd1;
        else if (step_next > 5'd16)
            step_next = 5'd16;

        gap_next = cfg.data[3:0];
        if (gap_next == 4'd0)
            gap_next = 4'd1;
        else if (gap_next > 4'd8)
            gap_next = 4'd8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_height_reg  <= 9'd1;
            image_width_reg   <= 9'd1;
            result_height_reg <= 9'd1;
            result_width_reg  <= 9'd1;
            step_size_reg     <= 5'd1;
            pad_amount_reg    <= 4'd0;
            in_gap_reg        <= 4'd1;
            out_gap_reg       <= 4'd1;
        end
        else if (cfg.valid)
        begin
            case (cte_pkg::cte_reg_t'(cfg.index))
                cte_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= dim_next;
                cte_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= dim_next;
                cte_pkg::REG_RESULT_HEIGHT: result_height_reg <= dim_next;
                cte_pkg::REG_RESULT_WIDTH:  result_width_reg  <= dim_next;
                cte_pkg::REG_STEP_SIZE:     step_size_reg     <= step_next;
                cte_pkg::REG_PAD_AMOUNT:    pad_amount_reg    <= cfg.data[3:0];
                cte_pkg::REG_IN_GAP:        in_gap_reg        <= gap_next;
                cte_pkg::REG_OUT_GAP:       out_gap_reg       <= gap_next;
                default: ;
            endcase
        end
    end

    // derived sizes follow the registers in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_gap_sq_reg  <= 7'd1;
            out_gap_sq_reg <= 7'd1;
            full_in_h_reg  <= 12'd1;
            full_in_w_reg  <= 12'd1;
            full_out_h_reg <= 12'd1;
            full_out_w_reg <= 12'd1;
        end
        else
        begin
            in_gap_sq_reg  <= 7'(7'(in_gap_reg) * 7'(in_gap_reg));
            out_gap_sq_reg <= 7'(7'(out_gap_reg) * 7'(out_gap_reg));
            full_in_h_reg  <= 12'(12'(image_height_reg) * 12'(in_gap_reg));
            full_in_w_reg  <= 12'(12'(image_width_reg) * 12'(in_gap_reg));
            full_out_h_reg <= 12'(12'(result_height_reg) * 12'(out_gap_reg));
            full_out_w_reg <= 12'(12'(result_width_reg) * 12'(out_gap_reg));
        end
    end

    always_comb
    begin
        regs.image_height  = image_height_reg;
        regs.image_width   = image_width_reg;
        regs.result_height = result_height_reg;
        regs.result_width  = result_width_reg;
        regs.step_size     = step_size_reg;
        regs.pad_amount    = pad_amount_reg;
        regs.in_gap        = in_gap_reg;
        regs.out_gap       = out_gap_reg;
        regs.in_gap_sq     = in_gap_sq_reg;
        regs.out_gap_sq    = out_gap_sq_reg;
        regs.full_in_h     = full_in_h_reg;
        regs.full_in_w     = full_in_w_reg;
        regs.full_out_h    = full_out_h_reg;
        regs.full_out_w    = full_out_w_reg;
    end

endmodule

[rtl/conv_toeplitz_entry_address.sv]
// ----------------------------------------------------------------------------
// conv_toeplitz_entry_address
// Computes the row and column of one kernel weight in the channel
// multiplexed Toeplitz matrix of a lowered 2-D convolution.
// ----------------------------------------------------------------------------
// Six-stage pipeline: one word can enter every cycle, pausing only while
// egress holds back a finished word. The depth is set by the chain decompose
// channel, split block offset, add plane offsets, check padding, multiply by
// plane width, classify. A word may follow a register write in the very next
// cycle: the derived plane sizes are registered from the written values and
// settle before that word reaches the stages that use them. Status 0 marks a
// stored entry; 1 a zero weight, 2 a pixel in the padding and 3 coordinates
// out of range or an address beyond 24 bits, and then row and column read 0.
// The weight always passes through unchanged.
module conv_toeplitz_entry_address (
    input  logic      clk,
    input  logic      rst_n,
    cte_cfg_if.sink   cfg,
    cte_in_if.sink    ingress,
    cte_out_if.source egress
);

    cte_pkg::cte_cfg_t regs;

    cte_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    logic adv;
    logic [6:1] valid_reg;

    // whole pipe moves when the output register is free or being taken
    assign adv           = !valid_reg[6] || egress.ready;
    assign ingress.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[5:1], ingress.valid};
    end

    // stage 1: super channel indexes, stride offsets, range and zero checks
    logic [7:0]         s1_co_reg, s1_ci_reg, s1_pr_reg, s1_pc_reg;
    logic [7:0]         s1_osup_reg, s1_isup_reg;
    logic [12:0]        s1_hs_reg, s1_ws_reg;
    logic               s1_range_reg, s1_zero_reg;
    logic signed [31:0] s1_w_reg;
    logic               range_next;

    always_comb
    begin
        range_next = (32'(ingress.out_chan) >= cte_pkg::MAX_CHANNELS)
                  || (32'(ingress.in_chan) >= cte_pkg::MAX_CHANNELS)
                  || (32'(ingress.tap_row) >= cte_pkg::MAX_KERNEL)
                  || (32'(ingress.tap_col) >= cte_pkg::MAX_KERNEL)
                  || ({1'b0, ingress.pos_row} >= regs.result_height)
                  || ({1'b0, ingress.pos_col} >= regs.result_width);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_co_reg    <= ingress.out_chan;
            s1_ci_reg    <= ingress.in_chan;
            s1_pr_reg    <= ingress.pos_row;
            s1_pc_reg    <= ingress.pos_col;
            s1_osup_reg  <= cte_pkg::div_by_gap_sq(ingress.out_chan, regs.out_gap);
            s1_isup_reg  <= cte_pkg::div_by_gap_sq(ingress.in_chan, regs.in_gap);
            s1_hs_reg    <= 13'(13'(ingress.tap_row) * 13'(cte_pkg::DILATION))
                          + 13'(13'(ingress.pos_row) * 13'(regs.step_size));
            s1_ws_reg    <= 13'(13'(ingress.tap_col) * 13'(cte_pkg::DILATION))
                          + 13'(13'(ingress.pos_col) * 13'(regs.step_size));
            s1_range_reg <= range_next;
            s1_zero_reg  <= (ingress.weight_in == 32'sd0);
            s1_w_reg     <= ingress.weight_in;
        end
    end

    // stage 2: block offsets within super channel, scaled plane offsets
    logic [5:0]         s2_oblk_reg, s2_iblk_reg;
    logic [18:0]        s2_osup_foh_reg, s2_isup_fh_reg;
    logic [10:0]        s2_prog_reg, s2_pcog_reg;
    logic [15:0]        s2_hsg_reg, s2_wsg_reg;
    logic               s2_range_reg, s2_zero_reg;
    logic signed [31:0] s2_w_reg;
    logic [14:0]        osup_sq_next, isup_sq_next;

    always_comb
    begin
        osup_sq_next = 15'(s1_osup_reg) * 15'(regs.out_gap_sq);
        isup_sq_next = 15'(s1_isup_reg) * 15'(regs.in_gap_sq);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_oblk_reg     <= 6'(s1_co_reg - osup_sq_next[7:0]);
            s2_iblk_reg     <= 6'(s1_ci_reg - isup_sq_next[7:0]);
            s2_osup_foh_reg <= 19'(19'(s1_osup_reg) * 19'(regs.full_out_h));
            s2_isup_fh_reg  <= 19'(19'(s1_isup_reg) * 19'(regs.full_in_h));
            s2_prog_reg     <= 11'(11'(s1_pr_reg) * 11'(regs.out_gap));
            s2_pcog_reg     <= 11'(11'(s1_pc_reg) * 11'(regs.out_gap));
            s2_hsg_reg      <= 16'(16'(s1_hs_reg) * 16'(regs.in_gap));
            s2_wsg_reg      <= 16'(16'(s1_ws_reg) * 16'(regs.in_gap));
            s2_range_reg    <= s1_range_reg;
            s2_zero_reg     <= s1_zero_reg;
            s2_w_reg        <= s1_w_reg;
        end
    end

    // stage 3: split block offset into row and column, physical coordinates
    logic [10:0]        s3_frow_reg, s3_fcol_reg;
    logic [15:0]        s3_ph_reg, s3_pw_reg;
    logic [18:0]        s3_osup_foh_reg, s3_isup_fh_reg;
    logic               s3_range_reg, s3_zero_reg;
    logic signed [31:0] s3_w_reg;
    logic [2:0]         oq_next, iq_next, or_next, ir_next;
    logic [6:0]         oq_g_next, iq_g_next;

    always_comb
    begin
        oq_next   = cte_pkg::div_by_gap(s2_oblk_reg, regs.out_gap);
        iq_next   = cte_pkg::div_by_gap(s2_iblk_reg, regs.in_gap);
        oq_g_next = 7'(oq_next) * 7'(regs.out_gap);
        iq_g_next = 7'(iq_next) * 7'(regs.in_gap);
        or_next   = 3'(7'(s2_oblk_reg) - oq_g_next);
        ir_next   = 3'(7'(s2_iblk_reg) - iq_g_next);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_frow_reg     <= s2_prog_reg + 11'(oq_next);
            s3_fcol_reg     <= s2_pcog_reg + 11'(or_next);
            s3_ph_reg       <= s2_hsg_reg + 16'(iq_next);
            s3_pw_reg       <= s2_wsg_reg + 16'(ir_next);
            s3_osup_foh_reg <= s2_osup_foh_reg;
            s3_isup_fh_reg  <= s2_isup_fh_reg;
            s3_range_reg    <= s2_range_reg;
            s3_zero_reg     <= s2_zero_reg;
            s3_w_reg        <= s2_w_reg;
        end
    end

    // stage 4: padding test, partial row and column sums
    logic [19:0]        s4_trow_reg, s4_hrow_reg;
    logic [10:0]        s4_fcol_reg;
    logic [15:0]        s4_wcol_reg;
    logic               s4_pad_reg, s4_range_reg, s4_zero_reg;
    logic signed [31:0] s4_w_reg;
    logic [16:0]        pad_ext_next, h_lim_next, w_lim_next;
    logic               pad_next;

    always_comb
    begin
        pad_ext_next = 17'(regs.pad_amount);
        h_lim_next   = pad_ext_next + 17'(regs.full_in_h);
        w_lim_next   = pad_ext_next + 17'(regs.full_in_w);
        pad_next     = (17'(s3_ph_reg) < pad_ext_next) || (17'(s3_ph_reg) >= h_lim_next)
                    || (17'(s3_pw_reg) < pad_ext_next) || (17'(s3_pw_reg) >= w_lim_next);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_trow_reg  <= 20'(s3_osup_foh_reg) + 20'(s3_frow_reg);
            s4_hrow_reg  <= 20'(s3_isup_fh_reg) + 20'(s3_ph_reg) - 20'(regs.pad_amount);
            s4_fcol_reg  <= s3_fcol_reg;
            s4_wcol_reg  <= s3_pw_reg - 16'(regs.pad_amount);
            s4_pad_reg   <= pad_next;
            s4_range_reg <= s3_range_reg;
            s4_zero_reg  <= s3_zero_reg;
            s4_w_reg     <= s3_w_reg;
        end
    end

    // stage 5: full row and column addresses
    logic [31:0]        s5_row_reg, s5_col_reg;
    logic               s5_pad_reg, s5_range_reg, s5_zero_reg;
    logic signed [31:0] s5_w_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_row_reg   <= 32'(32'(s4_trow_reg) * 32'(regs.full_out_w)) + 32'(s4_fcol_reg);
            s5_col_reg   <= 32'(32'(s4_hrow_reg) * 32'(regs.full_in_w)) + 32'(s4_wcol_reg);
            s5_pad_reg   <= s4_pad_reg;
            s5_range_reg <= s4_range_reg;
            s5_zero_reg  <= s4_zero_reg;
            s5_w_reg     <= s4_w_reg;
        end
    end

    // stage 6: classification and output register
    cte_pkg::cte_status_t status_next, status_reg;
    logic [23:0]          row_reg, col_reg;
    logic signed [31:0]   w_reg;

    always_comb
    begin
        if (s5_range_reg || (s5_row_reg[31:24] != 8'd0))
            status_next = cte_pkg::ST_RANGE;
        else if (s5_zero_reg)
            status_next = cte_pkg::ST_ZERO;
        else if (s5_pad_reg)
            status_next = cte_pkg::ST_PAD;
        else if (s5_col_reg[31:24] != 8'd0)
            status_next = cte_pkg::ST_RANGE;
        else
            status_next = cte_pkg::ST_STORED;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= status_next;
            row_reg    <= (status_next == cte_pkg::ST_STORED) ? s5_row_reg[23:0] : 24'd0;
            col_reg    <= (status_next == cte_pkg::ST_STORED) ? s5_col_reg[23:0] : 24'd0;
            w_reg      <= s5_w_reg;
        end
    end

    assign egress.valid      = valid_reg[6];
    assign egress.status     = status_reg;
    assign egress.matrix_row = row_reg;
    assign egress.matrix_col = col_reg;
    assign egress.weight_out = w_reg;

endmodule

[test/conv_toeplitz_entry_address_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv_toeplitz_entry_address_tb
// Streams kernel weight words through the Toeplitz entry address generator
// under several register settings and random handshake pressure, and checks
// every entry against a behavioral model of the row/column placement.
// ----------------------------------------------------------------------------
module conv_toeplitz_entry_address_tb;

    localparam longint unsigned ADDR_SPAN = 64'd16777216;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int PHASE_WORDS  = 225;

    typedef struct packed {
        logic [7:0]         out_chan;
        logic [7:0]         in_chan;
        logic [3:0]         tap_row;
        logic [3:0]         tap_col;
        logic [7:0]         pos_row;
        logic [7:0]         pos_col;
        logic signed [31:0] weight;
    } kernel_word_t;

    typedef struct packed {
        cte_pkg::cte_status_t status;
        logic [23:0]          row;
        logic [23:0]          col;
        logic signed [31:0]   weight;
    } matrix_entry_t;

    logic clk;
    logic rst_n;

    cte_cfg_if cfg_ch ();
    cte_in_if  weight_ch ();
    cte_out_if entry_ch ();

    conv_toeplitz_entry_address dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .ingress (weight_ch),
        .egress  (entry_ch)
    );

    kernel_word_t    kernel_words [$];
    matrix_entry_t   expected_entries [$];
    longint unsigned setting [8];
    logic [15:0]     plan [8];
    int              words_unsent;
    int              mismatches;
    int              cycle_count;
    int              send_idle_pct;
    int              recv_idle_pct;
    logic            word_taken;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // register write: mask to the field width, then clamp to the legal range
    function automatic void apply_setting(cte_pkg::cte_reg_t r, logic [15:0] data);
        int unsigned     bits;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned v;
        case (r)
            cte_pkg::REG_IMAGE_HEIGHT, cte_pkg::REG_IMAGE_WIDTH,
            cte_pkg::REG_RESULT_HEIGHT, cte_pkg::REG_RESULT_WIDTH:
            begin
                bits = 9;
                lo   = 1;
                hi   = cte_pkg::MAX_DIM;
            end
            cte_pkg::REG_STEP_SIZE:
            begin
                bits = 5;
                lo   = 1;
                hi   = 16;
            end
            cte_pkg::REG_PAD_AMOUNT:
            begin
                bits = 4;
                lo   = 0;
                hi   = 15;
            end
            default:
            begin
                bits = 4;
                lo   = 1;
                hi   = 8;
            end
        endcase
        v = data & ((64'd1 << bits) - 1);
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        setting[r] = v;
    endfunction

    function automatic matrix_entry_t place_weight(kernel_word_t k);
        longint unsigned og, og2, osup, oblk, plane_h, plane_w, row;
        longint unsigned ig, ig2, isup, iblk, img_h, img_w, ph, pw, pad, col;
        matrix_entry_t   e;
        og      = setting[cte_pkg::REG_OUT_GAP];
        og2     = og * og;
        osup    = k.out_chan / og2;
        oblk    = k.out_chan % og2;
        plane_h = setting[cte_pkg::REG_RESULT_HEIGHT] * og;
        plane_w = setting[cte_pkg::REG_RESULT_WIDTH] * og;
        row     = osup * plane_h * plane_w + (k.pos_row * og + oblk / og) * plane_w
                  + k.pos_col * og + oblk % og;

        ig    = setting[cte_pkg::REG_IN_GAP];
        ig2   = ig * ig;
        isup  = k.in_chan / ig2;
        iblk  = k.in_chan % ig2;
        img_h = setting[cte_pkg::REG_IMAGE_HEIGHT] * ig;
        img_w = setting[cte_pkg::REG_IMAGE_WIDTH] * ig;
        ph    = (k.tap_row * cte_pkg::DILATION
                 + k.pos_row * setting[cte_pkg::REG_STEP_SIZE]) * ig + iblk / ig;
        pw    = (k.tap_col * cte_pkg::DILATION
                 + k.pos_col * setting[cte_pkg::REG_STEP_SIZE]) * ig + iblk % ig;
        pad   = setting[cte_pkg::REG_PAD_AMOUNT];
        col   = 0;

        e.status = cte_pkg::ST_STORED;
        e.weight = k.weight;
        if (k.out_chan >= cte_pkg::MAX_CHANNELS || k.in_chan >= cte_pkg::MAX_CHANNELS ||
            k.tap_row >= cte_pkg::MAX_KERNEL || k.tap_col >= cte_pkg::MAX_KERNEL ||
            k.pos_row >= setting[cte_pkg::REG_RESULT_HEIGHT] ||
            k.pos_col >= setting[cte_pkg::REG_RESULT_WIDTH] || row >= ADDR_SPAN)
            e.status = cte_pkg::ST_RANGE;
        else if (k.weight == 0)
            e.status = cte_pkg::ST_ZERO;
        else if (ph < pad || ph >= pad + img_h || pw < pad || pw >= pad + img_w)
            e.status = cte_pkg::ST_PAD;
        else
        begin
            col = isup * img_h * img_w + (ph - pad) * img_w + (pw - pad);
            if (col >= ADDR_SPAN)
                e.status = cte_pkg::ST_RANGE;
        end
        if (e.status != cte_pkg::ST_STORED)
        begin
            row = 0;
            col = 0;
        end
        e.row = row[23:0];
        e.col = col[23:0];
        return e;
    endfunction

    function automatic kernel_word_t random_weight_word();
        kernel_word_t k;
        int unsigned  pick;
        k.out_chan = 8'($urandom_range(255));
        k.in_chan  = 8'($urandom_range(255));
        k.tap_row  = 4'($urandom_range(15));
        k.tap_col  = 4'($urandom_range(15));
        k.pos_row  = 8'($urandom_range(255));
        k.pos_col  = 8'($urandom_range(255));
        // mostly aim inside the output plane with short taps so entries get stored
        if ($urandom_range(99) < 75)
        begin
            k.pos_row = 8'($urandom_range(int'(setting[cte_pkg::REG_RESULT_HEIGHT]) - 1));
            k.pos_col = 8'($urandom_range(int'(setting[cte_pkg::REG_RESULT_WIDTH]) - 1));
            k.tap_row = 4'($urandom_range(3));
            k.tap_col = 4'($urandom_range(3));
        end
        pick = $urandom_range(99);
        if (pick < 8)
            k.weight = 32'sd0;
        else if (pick < 10)
            k.weight = 32'sh8000_0000;
        else if (pick < 12)
            k.weight = 32'sh7FFF_FFFF;
        else if (pick < 14)
            k.weight = -32'sd1;
        else
            k.weight = $urandom;
        return k;
    endfunction

    task automatic queue_word(input kernel_word_t k);
        words_unsent++;
        kernel_words.insert(kernel_words.size(), k);
    endtask

    task automatic queue_directed(input logic [7:0] co, input logic [7:0] ci,
                                  input logic [3:0] kr, input logic [3:0] kc,
                                  input logic [7:0] pr, input logic [7:0] pc,
                                  input logic signed [31:0] w);
        queue_word('{co, ci, kr, kc, pr, pc, w});
    endtask

    task automatic program_registers();
        for (int r = 0; r < 8; r++)
        begin
            @(negedge clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= cte_pkg::cte_reg_t'(r);
            cfg_ch.data  <= plan[r];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            apply_setting(cte_pkg::cte_reg_t'(r), plan[r]);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        // let the derived plane sizes settle before new words are sent
        repeat (4) @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (words_unsent != 0 || expected_entries.size() != 0);
    endtask

    task automatic set_plan(input logic [15:0] ih, input logic [15:0] iw,
                            input logic [15:0] rh, input logic [15:0] rw,
                            input logic [15:0] st, input logic [15:0] pd,
                            input logic [15:0] ig, input logic [15:0] og);
        plan[cte_pkg::REG_IMAGE_HEIGHT]  = ih;
        plan[cte_pkg::REG_IMAGE_WIDTH]   = iw;
        plan[cte_pkg::REG_RESULT_HEIGHT] = rh;
        plan[cte_pkg::REG_RESULT_WIDTH]  = rw;
        plan[cte_pkg::REG_STEP_SIZE]     = st;
        plan[cte_pkg::REG_PAD_AMOUNT]    = pd;
        plan[cte_pkg::REG_IN_GAP]        = ig;
        plan[cte_pkg::REG_OUT_GAP]       = og;
    endtask

    task automatic random_plan();
        int unsigned ih, iw, st;
        ih = ($urandom_range(9) == 0) ? 256 : $urandom_range(1, 24);
        iw = ($urandom_range(9) == 0) ? 256 : $urandom_range(1, 24);
        st = ($urandom_range(9) == 0) ? 16 : $urandom_range(1, 3);
        set_plan(16'(ih), 16'(iw), 16'((ih - 1) / st + 1), 16'((iw - 1) / st + 1), 16'(st),
                 16'(($urandom_range(9) == 0) ? 15 : $urandom_range(2)),
                 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
        // some raw writes so that clamping and every data bit are exercised
        for (int r = 0; r < 8; r++)
            if ($urandom_range(99) < 15)
                plan[r] = 16'($urandom_range(16'hFFFF));
    endtask

    // weight word driver
    always @(negedge clk)
    begin : send_words
        kernel_word_t k;
        if (rst_n && (!weight_ch.valid || word_taken))
        begin
            if (kernel_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                k = kernel_words.pop_front();
                weight_ch.valid     <= 1'b1;
                weight_ch.out_chan  <= k.out_chan;
                weight_ch.in_chan   <= k.in_chan;
                weight_ch.tap_row   <= k.tap_row;
                weight_ch.tap_col   <= k.tap_col;
                weight_ch.pos_row   <= k.pos_row;
                weight_ch.pos_col   <= k.pos_col;
                weight_ch.weight_in <= k.weight;
            end
            else
                weight_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            entry_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // accept monitor and entry checker
    always @(posedge clk)
    begin : check_entries
        matrix_entry_t want;
        word_taken <= rst_n && weight_ch.valid && weight_ch.ready;
        if (rst_n && weight_ch.valid && weight_ch.ready)
        begin
            expected_entries.insert(expected_entries.size(),
                place_weight('{weight_ch.out_chan, weight_ch.in_chan,
                weight_ch.tap_row, weight_ch.tap_col, weight_ch.pos_row, weight_ch.pos_col,
                weight_ch.weight_in}));
            words_unsent--;
        end
        if (rst_n && entry_ch.valid && entry_ch.ready)
        begin
            if (expected_entries.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected entry: status %0d row %0d col %0d weight %h",
                             entry_ch.status, entry_ch.matrix_row, entry_ch.matrix_col,
                             entry_ch.weight_out);
                mismatches++;
            end
            else
            begin
                want = expected_entries.pop_front();
                if (entry_ch.status !== want.status || entry_ch.matrix_row !== want.row ||
                    entry_ch.matrix_col !== want.col || entry_ch.weight_out !== want.weight)
                begin
                    if (mismatches < 10)
                        $display({"entry mismatch: status exp %0d got %0d, row exp %0d got %0d,",
                                  " col exp %0d got %0d, weight exp %h got %h"},
                                 want.status, entry_ch.status, want.row, entry_ch.matrix_row,
                                 want.col, entry_ch.matrix_col, want.weight,
                                 entry_ch.weight_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[conv_toeplitz_entry_address] ERROR");
            $finish;
        end
    end

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cycle_count         = 0;
        mismatches          = 0;
        words_unsent        = 0;
        word_taken          = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = cte_pkg::REG_IMAGE_HEIGHT;
        cfg_ch.data         = '0;
        weight_ch.valid     = 1'b0;
        weight_ch.out_chan  = '0;
        weight_ch.in_chan   = '0;
        weight_ch.tap_row   = '0;
        weight_ch.tap_col   = '0;
        weight_ch.pos_row   = '0;
        weight_ch.pos_col   = '0;
        weight_ch.weight_in = '0;
        entry_ch.ready      = 1'b0;
        send_idle_pct       = 26;
        recv_idle_pct       = 48;
        set_plan(1, 1, 1, 1, 1, 0, 1, 1);
        for (int r = 0; r < 8; r++)
            apply_setting(cte_pkg::cte_reg_t'(r), plan[r]);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // small multiplexed image with a one pixel border
        set_plan(6, 6, 6, 6, 1, 1, 2, 2);
        program_registers();
        queue_directed(8'd5, 8'd6, 4'd1, 4'd2, 8'd2, 8'd3, 32'sh0001_0000);
        queue_directed(8'd5, 8'd6, 4'd1, 4'd2, 8'd2, 8'd3, 32'sd0);
        queue_directed(8'd0, 8'd0, 4'd0, 4'd0, 8'd0, 8'd0, 32'sd7);
        queue_directed(8'd1, 8'd2, 4'd15, 4'd0, 8'd5, 8'd1, 32'sd9);
        queue_directed(8'd1, 8'd2, 4'd0, 4'd0, 8'd6, 8'd1, 32'sd9);
        queue_directed(8'd1, 8'd2, 4'd0, 4'd0, 8'd1, 8'd255, 32'sd9);
        queue_directed(8'd1, 8'd2, 4'd0, 4'd0, 8'd6, 8'd1, 32'sd0);
        queue_directed(8'd0, 8'd0, 4'd0, 4'd0, 8'd0, 8'd0, 32'sd0);
        queue_directed(8'd255, 8'd255, 4'd15, 4'd15, 8'd5, 8'd5, 32'sh7FFF_FFFF);
        queue_directed(8'd3, 8'd1, 4'd1, 4'd1, 8'd1, 8'd1, 32'sh8000_0000);
        queue_directed(8'd7, 8'd3, 4'd2, 4'd0, 8'd4, 8'd2, -32'sd1);
        queue_directed(8'd2, 8'd3, 4'd0, 4'd1, 8'd0, 8'd0, 32'sd1);
        wait_drained();

        // full size planes with gap 3 so that both addresses can overflow 24 bits
        set_plan(256, 256, 256, 256, 1, 0, 3, 3);
        program_registers();
        queue_directed(8'd255, 8'd0, 4'd0, 4'd0, 8'd255, 8'd255, 32'sd1);
        queue_directed(8'd255, 8'd0, 4'd0, 4'd0, 8'd255, 8'd255, 32'sd0);
        queue_directed(8'd0, 8'd255, 4'd0, 4'd0, 8'd255, 8'd255, 32'sd5);
        queue_directed(8'd0, 8'd255, 4'd15, 4'd0, 8'd255, 8'd255, 32'sd5);
        queue_directed(8'd0, 8'd8, 4'd0, 4'd0, 8'd255, 8'd255, 32'sd5);
        queue_directed(8'd255, 8'd255, 4'd15, 4'd15, 8'd255, 8'd255, -32'sd3);
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 26;
            end
            else if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 0)
                set_plan(0, 1, 0, 1, 0, 0, 0, 1);
            else if (phase == 7)
                set_plan(256, 16'hFFFF, 256, 256, 16, 15, 8, 16'h000F);
            else
                random_plan();
            program_registers();
            repeat (PHASE_WORDS) queue_word(random_weight_word());
            wait_drained();
        end

        repeat (12) @(negedge clk);
        if (mismatches == 0)
            $display("[conv_toeplitz_entry_address] OK");
        else
            $display("[conv_toeplitz_entry_address] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/cte_pkg.sv
rtl/cte_in_if.sv
rtl/cte_out_if.sv
rtl/cte_cfg_if.sv
rtl/cte_cfg_regs.sv
rtl/conv_toeplitz_entry_address.sv
test/conv_toeplitz_entry_address_tb.sv
